// ===== rtl/btpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
package btpc_pkg;

    localparam int RAW_W              = 20;
    localparam int DIV_W              = 64;
    localparam int DEN_W              = 31;
    localparam int DEFAULT_FIFO_DEPTH = 4;

    localparam int FINE_OFFSET = 128000;
    localparam int PRESS_SCALE = 3125;
    localparam int PRESS_BASE  = 1048576;
    localparam int CENTI_ROUND = 128;

    typedef enum logic [1:0] {
        CFG_TEMP_COEFFS = 2'd0,
        CFG_PRESS_LOW   = 2'd1,
        CFG_PRESS_HIGH  = 2'd2,
        CFG_PRESS_NINE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_temp;
        logic [RAW_W-1:0] raw_press;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic signed [31:0] fine_temp;
        logic        [31:0] pressure_q24_8;
        logic               div_error;
    } out_item_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    typedef struct packed {
        logic        [RAW_W-1:0] raw_press;
        logic signed [33:0]      at2;
        logic        [32:0]      bb;
    } front_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic signed [31:0] fine_temp;
        logic               neg;
        logic               div_error;
    } div_tag_t;

endpackage

// ===== rtl/btpc_fifo.sv =====
// Small register FIFO that decouples the front stage from the back pipeline.
module btpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("fifo written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("fifo read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

// ===== rtl/btpc_front.sv =====
// Front stage: accepts an item and forms the first temperature products.
module btpc_front
    import btpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    input  coef_t       coef,
    output logic        push,
    output front_item_t push_data,
    input  logic        full
);

    logic        valid_reg, valid_next;
    front_item_t item_reg;
    front_item_t item_next;

    logic signed [17:0] a_val;
    logic signed [16:0] b_val;
    logic signed [33:0] b_sq;

    assign in_ready  = !valid_reg || !full;
    assign push      = valid_reg && !full;
    assign push_data = item_reg;

    always_comb
    begin
        a_val = $signed({1'b0, in_data.raw_temp[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
        b_val = $signed({1'b0, in_data.raw_temp[19:4]}) - $signed({1'b0, coef.t1});
        b_sq  = b_val * b_val;
        item_next.raw_press = in_data.raw_press;
        item_next.at2       = a_val * $signed(coef.t2);
        item_next.bb        = b_sq[32:0];
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/btpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module btpc_div
    import btpc_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [DIV_W-1:0] quotient,
    output logic [TAG_W-1:0] out_tag
);

    logic             valid_reg [0:DIV_W-1];
    logic [DEN_W-1:0] rem_reg   [0:DIV_W-1];
    logic [DIV_W-1:0] nq_reg    [0:DIV_W-1];
    logic [DEN_W-1:0] den_reg   [0:DIV_W-1];
    logic [TAG_W-1:0] tag_reg   [0:DIV_W-1];

    logic [DEN_W-1:0] rem_in    [0:DIV_W-1];
    logic [DIV_W-1:0] nq_in     [0:DIV_W-1];
    logic [DEN_W-1:0] den_in    [0:DIV_W-1];
    logic [DEN_W:0]   trial     [0:DIV_W-1];
    logic [DEN_W+1:0] diff      [0:DIV_W-1];
    logic [DEN_W-1:0] rem_next  [0:DIV_W-1];
    logic [DIV_W-1:0] nq_next   [0:DIV_W-1];

    // Each stage shifts one dividend bit into the partial remainder and
    // subtracts the divisor when it fits.
    always_comb
    begin
        for (int i = 0; i < DIV_W; i++)
        begin
            if (i == 0)
            begin
                rem_in[i] = '0;
                nq_in[i]  = dividend;
                den_in[i] = divisor;
            end
            else
            begin
                rem_in[i] = rem_reg[i-1];
                nq_in[i]  = nq_reg[i-1];
                den_in[i] = den_reg[i-1];
            end
            trial[i] = {rem_in[i], nq_in[i][DIV_W-1]};
            diff[i]  = {1'b0, trial[i]} - {2'b00, den_in[i]};
            if (!diff[i][DEN_W+1])
            begin
                rem_next[i] = diff[i][DEN_W-1:0];
            end
            else
            begin
                rem_next[i] = trial[i][DEN_W-1:0];
            end
            nq_next[i] = {nq_in[i][DIV_W-2:0], ~diff[i][DEN_W+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DIV_W; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
                den_reg[i] <= den_in[i];
            end
            tag_reg[0] <= in_tag;
            for (int i = 1; i < DIV_W; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_W-1];
    assign quotient  = nq_reg[DIV_W-1];
    assign out_tag   = tag_reg[DIV_W-1];

endmodule

// ===== rtl/btpc_back.sv =====
// Back pipeline: finishes temperature, forms the pressure divisor and result.
module btpc_back
    import btpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  coef_t       coef,
    output logic        pop,
    input  front_item_t pop_data,
    input  logic        empty,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic en;

    // Stage valid bits.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic out_valid_reg;
    logic div_valid;

    // Stage 1: temperature partial terms.
    logic signed [22:0] s1_tv1_reg;
    logic signed [37:0] s1_t3p_reg;
    logic [RAW_W-1:0]   s1_press_reg;
    logic signed [37:0] s1_t3p_next;

    // Stage 2: fine temperature.
    logic signed [31:0] s2_tfine_reg, s2_tfine_next;
    logic [RAW_W-1:0]   s2_press_reg;

    // Stage 3: products of the temperature offset.
    logic signed [32:0] s3_v1;
    logic signed [65:0] s3_vsq;
    logic signed [48:0] s3_v1p5;
    logic signed [48:0] s3_v1p2;
    logic signed [35:0] s3_tc5;
    logic [63:0]        s3_vsq_reg, s3_v1p5_reg, s3_v1p2_reg;
    logic signed [31:0] s3_tcenti_reg, s3_tfine_reg;
    logic [RAW_W-1:0]   s3_press_reg;

    // Stage 4: coefficient products of the squared offset.
    logic signed [79:0] s4_prod6, s4_prod3;
    logic [63:0]        s4_prod6_reg, s4_prod3_reg, s4_v1p5_reg, s4_v1p2_reg;
    logic signed [31:0] s4_tcenti_reg, s4_tfine_reg;
    logic [RAW_W-1:0]   s4_press_reg;

    // Stage 5: sums.
    logic [63:0]        s5_v2_next, s5_x_next, s5_w;
    logic [63:0]        s5_v2_reg, s5_x_reg;
    logic signed [31:0] s5_tcenti_reg, s5_tfine_reg;
    logic [RAW_W-1:0]   s5_press_reg;

    // Stage 6: divisor and numerator base.
    logic signed [80:0] s6_y;
    logic [20:0]        s6_pp;
    logic [63:0]        s6_n0_next, s6_n0_reg;
    logic [DEN_W-1:0]   s6_d_reg;
    logic signed [31:0] s6_tcenti_reg, s6_tfine_reg;

    // Stage 7: scaled numerator.
    logic [75:0]        s7_m;
    logic [63:0]        s7_numer_reg;
    logic [DEN_W-1:0]   s7_d_reg;
    logic signed [31:0] s7_tcenti_reg, s7_tfine_reg;

    // Stage 8: magnitudes and signs for the divider.
    logic [63:0]        s8_ma_reg;
    logic [DEN_W-1:0]   s8_md_reg;
    div_tag_t           s8_tag_reg, s8_tag_next;

    logic [DIV_W-1:0]   div_q;
    logic [$bits(div_tag_t)-1:0] div_tag_bits;
    div_tag_t           div_tag;

    // Post-divide stages.
    logic [63:0]        p1_p_reg;
    div_tag_t           p1_tag_reg;
    logic [63:0]        p2_s;
    logic [63:0]        p2_lolo, p2_cross_full;
    logic signed [79:0] p2_p8p;
    logic [63:0]        p2_lolo_reg, p2_p8p_reg, p2_p_reg;
    logic [31:0]        p2_cross_reg;
    div_tag_t           p2_tag_reg;
    logic [63:0]        p3_ssq_reg, p3_p8p_reg, p3_p_reg;
    div_tag_t           p3_tag_reg;
    logic signed [79:0] p4_t;
    logic [63:0]        p4_t_reg, p4_p8p_reg, p4_p_reg;
    div_tag_t           p4_tag_reg;
    logic [63:0]        o_v1f, o_v2f, o_sum, o_res, o_p7;
    out_item_t          out_data_reg, out_data_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !empty;

    always_comb
    begin
        // Stage 1
        s1_t3p_next = $signed({1'b0, pop_data.bb[32:12]}) * $signed(coef.t3);

        // Stage 2
        s2_tfine_next = {{9{s1_tv1_reg[22]}}, s1_tv1_reg}
                      + {{8{s1_t3p_reg[37]}}, s1_t3p_reg[37:14]};

        // Stage 3
        s3_v1   = $signed({s2_tfine_reg[31], s2_tfine_reg}) - $signed(33'(FINE_OFFSET));
        s3_vsq  = s3_v1 * s3_v1;
        s3_v1p5 = s3_v1 * $signed(coef.p5);
        s3_v1p2 = s3_v1 * $signed(coef.p2);
        s3_tc5  = $signed({{4{s2_tfine_reg[31]}}, s2_tfine_reg}) * $signed(36'd5)
                + $signed(36'(CENTI_ROUND));

        // Stage 4
        s4_prod6 = $signed(s3_vsq_reg) * $signed(coef.p6);
        s4_prod3 = $signed(s3_vsq_reg) * $signed(coef.p3);

        // Stage 5
        s5_v2_next = s4_prod6_reg + {s4_v1p5_reg[46:0], 17'b0}
                   + {{13{coef.p4[15]}}, coef.p4, 35'b0};
        s5_w       = {{8{s4_prod3_reg[63]}}, s4_prod3_reg[63:8]}
                   + {s4_v1p2_reg[51:0], 12'b0};
        s5_x_next  = s5_w + {16'b0, 1'b1, 47'b0};

        // Stage 6
        s6_y       = $signed(s5_x_reg) * $signed({1'b0, coef.p1});
        s6_pp      = 21'(PRESS_BASE) - {1'b0, s5_press_reg};
        s6_n0_next = {12'b0, s6_pp, 31'b0} - s5_v2_reg;

        // Stage 7
        s7_m = s6_n0_reg * 76'(PRESS_SCALE);

        // Stage 8
        s8_tag_next.temp_centi = s7_tcenti_reg;
        s8_tag_next.fine_temp  = s7_tfine_reg;
        s8_tag_next.neg        = s7_numer_reg[63] ^ s7_d_reg[DEN_W-1];
        s8_tag_next.div_error  = (s7_d_reg == '0);

        // Post-divide
        p2_s          = {{13{p1_p_reg[63]}}, p1_p_reg[63:13]};
        p2_lolo       = p2_s[31:0] * p2_s[31:0];
        p2_cross_full = p2_s[31:0] * p2_s[63:32];
        p2_p8p        = $signed(p1_p_reg) * $signed(coef.p8);
        p4_t          = $signed(p3_ssq_reg) * $signed(coef.p9);

        o_v1f = {{25{p4_t_reg[63]}}, p4_t_reg[63:25]};
        o_v2f = {{19{p4_p8p_reg[63]}}, p4_p8p_reg[63:19]};
        o_sum = p4_p_reg + o_v1f + o_v2f;
        o_p7  = {{48{coef.p7[15]}}, coef.p7};
        o_res = {{8{o_sum[63]}}, o_sum[63:8]} + {o_p7[59:0], 4'b0};

        out_data_next.temp_centi     = p4_tag_reg.temp_centi;
        out_data_next.fine_temp      = p4_tag_reg.fine_temp;
        out_data_next.div_error      = p4_tag_reg.div_error;
        out_data_next.pressure_q24_8 = p4_tag_reg.div_error ? 32'd0 : o_res[31:0];
    end

    btpc_div #(
        .TAG_W($bits(div_tag_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s8_valid_reg),
        .dividend (s8_ma_reg),
        .divisor  (s8_md_reg),
        .in_tag   (s8_tag_reg),
        .out_valid(div_valid),
        .quotient (div_q),
        .out_tag  (div_tag_bits)
    );

    assign div_tag = div_tag_t'(div_tag_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            p1_valid_reg  <= div_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tv1_reg    <= pop_data.at2[33:11];
            s1_t3p_reg    <= s1_t3p_next;
            s1_press_reg  <= pop_data.raw_press;

            s2_tfine_reg  <= s2_tfine_next;
            s2_press_reg  <= s1_press_reg;

            s3_vsq_reg    <= s3_vsq[63:0];
            s3_v1p5_reg   <= {{15{s3_v1p5[48]}}, s3_v1p5};
            s3_v1p2_reg   <= {{15{s3_v1p2[48]}}, s3_v1p2};
            s3_tcenti_reg <= {{4{s3_tc5[35]}}, s3_tc5[35:8]};
            s3_tfine_reg  <= s2_tfine_reg;
            s3_press_reg  <= s2_press_reg;

            s4_prod6_reg  <= s4_prod6[63:0];
            s4_prod3_reg  <= s4_prod3[63:0];
            s4_v1p5_reg   <= s3_v1p5_reg;
            s4_v1p2_reg   <= s3_v1p2_reg;
            s4_tcenti_reg <= s3_tcenti_reg;
            s4_tfine_reg  <= s3_tfine_reg;
            s4_press_reg  <= s3_press_reg;

            s5_v2_reg     <= s5_v2_next;
            s5_x_reg      <= s5_x_next;
            s5_tcenti_reg <= s4_tcenti_reg;
            s5_tfine_reg  <= s4_tfine_reg;
            s5_press_reg  <= s4_press_reg;

            s6_d_reg      <= s6_y[63:33];
            s6_n0_reg     <= s6_n0_next;
            s6_tcenti_reg <= s5_tcenti_reg;
            s6_tfine_reg  <= s5_tfine_reg;

            s7_numer_reg  <= s7_m[63:0];
            s7_d_reg      <= s6_d_reg;
            s7_tcenti_reg <= s6_tcenti_reg;
            s7_tfine_reg  <= s6_tfine_reg;

            s8_ma_reg  <= s7_numer_reg[63] ? (64'd0 - s7_numer_reg) : s7_numer_reg;
            s8_md_reg  <= s7_d_reg[DEN_W-1] ? (DEN_W'(0) - s7_d_reg) : s7_d_reg;
            s8_tag_reg <= s8_tag_next;

            p1_p_reg   <= div_tag.neg ? (64'd0 - div_q) : div_q;
            p1_tag_reg <= div_tag;

            p2_lolo_reg  <= p2_lolo;
            p2_cross_reg <= p2_cross_full[31:0];
            p2_p8p_reg   <= p2_p8p[63:0];
            p2_p_reg     <= p1_p_reg;
            p2_tag_reg   <= p1_tag_reg;

            // Low half of the square: cross terms appear twice, hence the extra shift.
            p3_ssq_reg <= p2_lolo_reg + {p2_cross_reg[30:0], 33'b0};
            p3_p8p_reg <= p2_p8p_reg;
            p3_p_reg   <= p2_p_reg;
            p3_tag_reg <= p2_tag_reg;

            p4_t_reg   <= p4_t[63:0];
            p4_p8p_reg <= p3_p8p_reg;
            p4_p_reg   <= p3_p_reg;
            p4_tag_reg <= p3_tag_reg;

            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/baro_temp_press_compensation_top.sv =====
// Top level of the barometric temperature and pressure compensation block.
//
// The block turns one raw 20-bit temperature reading and one raw 20-bit
// pressure reading into the fine temperature, the temperature in hundredths
// of a degree Celsius and the pressure in pascals as unsigned Q24.8, using the
// integer compensation formulas with the factory calibration words written
// through the configuration port. It takes one item per clock while the output
// side does not stall; the latency is set mostly by the 64-stage pipelined
// divider, which resolves one quotient bit per stage. A front register forms
// the first temperature products and hands each item to a short FIFO, so the
// input and output sides can stall independently. When the pressure divisor
// comes out zero the item is still returned, with div_error set and pressure 0.
// Calibration registers must be written only while no item is in flight.
module baro_temp_press_compensation_top
    import btpc_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [63:0] cfg_data
);

    // Calibration registers, laid out as the configuration map describes.
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    coef_t       coef;
    logic        push, pop, full, empty;
    front_item_t push_data;
    front_item_t pop_data;

    // Writes are always taken; cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                CFG_PRESS_LOW:   press_low_reg   <= cfg_data;
                CFG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                CFG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:         temp_coeffs_reg <= temp_coeffs_reg;
            endcase
        end
    end

    // Split the packed words into the individual coefficients.
    always_comb
    begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = $signed(temp_coeffs_reg[31:16]);
        coef.t3 = $signed(temp_coeffs_reg[47:32]);
        coef.p1 = press_low_reg[15:0];
        coef.p2 = $signed(press_low_reg[31:16]);
        coef.p3 = $signed(press_low_reg[47:32]);
        coef.p4 = $signed(press_low_reg[63:48]);
        coef.p5 = $signed(press_high_reg[15:0]);
        coef.p6 = $signed(press_high_reg[31:16]);
        coef.p7 = $signed(press_high_reg[47:32]);
        coef.p8 = $signed(press_high_reg[63:48]);
        coef.p9 = $signed(press_nine_reg);
    end

    btpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .coef     (coef),
        .push     (push),
        .push_data(push_data),
        .full     (full)
    );

    btpc_fifo #(
        .WIDTH($bits(front_item_t)),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    btpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // A divide error must always come with a zero pressure.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.div_error) |-> (out_data.pressure_q24_8 == '0))
        else $error("div_error item carries nonzero pressure");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the barometric temperature and pressure compensation block.
`timescale 1ns / 1ps

module tb_top
    import btpc_pkg::*;
();

    localparam int LATENCY_CYCLES = 78;
    localparam int ERR_REPORT_MAX = 10;

    // The scoreboard keeps its own copy of the calibration words and computes the
    // expected result of every accepted item.  Results must come back in order.
    class comp_scoreboard;
        logic [47:0] temp_words;
        logic [63:0] press_low_words;
        logic [63:0] press_high_words;
        logic [15:0] press_nine_word;
        out_item_t   pending_results[$];
        int          mismatch_count;

        function new();
            temp_words       = '0;
            press_low_words  = '0;
            press_high_words = '0;
            press_nine_word  = '0;
            mismatch_count   = 0;
        endfunction

        function void write_coeff(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_TEMP_COEFFS: temp_words       = value[47:0];
                CFG_PRESS_LOW:   press_low_words  = value;
                CFG_PRESS_HIGH:  press_high_words = value;
                CFG_PRESS_NINE:  press_nine_word  = value[15:0];
                default: ;
            endcase
        endfunction

        // Compensation arithmetic.  The temperature terms are exact in 64 bits,
        // and the pressure path wraps modulo 2^64 with arithmetic right shifts.
        function out_item_t compensate(in_item_t item);
            out_item_t          res;
            logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] adc_t, adc_p, dt, db, tv1, tv2, tfine, tcenti;
            logic signed [63:0] v1, v2, p;
            t1 = {48'd0, temp_words[15:0]};
            t2 = {{48{temp_words[31]}}, temp_words[31:16]};
            t3 = {{48{temp_words[47]}}, temp_words[47:32]};
            p1 = {48'd0, press_low_words[15:0]};
            p2 = {{48{press_low_words[31]}}, press_low_words[31:16]};
            p3 = {{48{press_low_words[47]}}, press_low_words[47:32]};
            p4 = {{48{press_low_words[63]}}, press_low_words[63:48]};
            p5 = {{48{press_high_words[15]}}, press_high_words[15:0]};
            p6 = {{48{press_high_words[31]}}, press_high_words[31:16]};
            p7 = {{48{press_high_words[47]}}, press_high_words[47:32]};
            p8 = {{48{press_high_words[63]}}, press_high_words[63:48]};
            p9 = {{48{press_nine_word[15]}}, press_nine_word};
            adc_t = {44'd0, item.raw_temp};
            adc_p = {44'd0, item.raw_press};

            dt     = (adc_t >>> 3) - (t1 <<< 1);
            tv1    = (dt * t2) >>> 11;
            db     = (adc_t >>> 4) - t1;
            tv2    = (((db * db) >>> 12) * t3) >>> 14;
            tfine  = tv1 + tv2;
            tcenti = (tfine * 5 + 128) >>> 8;

            v1 = tfine - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

            res.temp_centi = tcenti[31:0];
            res.fine_temp  = tfine[31:0];
            if (v1 == 0)
            begin
                res.div_error      = 1'b1;
                res.pressure_q24_8 = '0;
            end
            else
            begin
                p = 64'sd1048576 - adc_p;
                p = ((p <<< 31) - v2) * 3125;
                // Most negative value over minus one wraps to itself.
                if (p == {1'b1, 63'd0} && v1 == -64'sd1)
                    p = p;
                else
                    p = p / v1;
                v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                v2 = (p8 * p) >>> 19;
                p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
                res.div_error      = 1'b0;
                res.pressure_q24_8 = p[31:0];
            end
            return res;
        endfunction

        function void note_input(in_item_t item);
            pending_results.push_back(compensate(item));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ERR_REPORT_MAX)
                    $display("Unexpected result %h with nothing pending", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.temp_centi !== want.temp_centi || got.fine_temp !== want.fine_temp ||
                got.pressure_q24_8 !== want.pressure_q24_8 ||
                got.div_error !== want.div_error)
            begin
                mismatch_count++;
                if (mismatch_count <= ERR_REPORT_MAX)
                    $display("Mismatch: temp %0d/%0d fine %0d/%0d press %h/%h err %b/%b",
                        want.temp_centi, got.temp_centi, want.fine_temp, got.fine_temp,
                        want.pressure_q24_8, got.pressure_q24_8,
                        want.div_error, got.div_error);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [63:0] cfg_data;

    comp_scoreboard board;

    // Idle rates in percent for the two sides; changed between phases.
    int send_idle_pct;
    int recv_stall_pct;
    // When set, the receiver holds off for this many cycles and then clears it.
    int hold_off_cycles;

    baro_temp_press_compensation_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run: far beyond the slowest correct run with every stall.
    initial
    begin
        #(12 * 2000000);
        $display("[baro_temp_press_compensation_top] ERROR");
        $finish;
    end

    // Sample accepted items at the clock edge and feed the scoreboard.  Inputs are
    // driven with nonblocking assignments, so the values seen here are stable.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_input(in_data);
            if (out_valid && out_ready)
                board.check_result(out_data);
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked for one.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until it is accepted, with random gaps before.
    // Valid stays high after acceptance so that items can follow back to back;
    // it drops during a gap or when the stream is drained.
    task automatic send_item(logic [19:0] temp_reading, logic [19:0] press_reading);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{raw_temp: temp_reading, raw_press: press_reading};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.write_coeff(idx, value);
        @(posedge clk);
    endtask

    // Stop offering items, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES + 10) @(posedge clk);
    endtask

    // Calibration words close to a real part, with some random spread.
    task automatic write_typical_coeffs();
        logic [15:0] w[12];
        w[0]  = 16'd27504 + 16'($urandom_range(2000));
        w[1]  = 16'd26435 + 16'($urandom_range(2000));
        w[2]  = 16'hFC18 + 16'($urandom_range(200));
        w[3]  = 16'd36477 + 16'($urandom_range(2000));
        w[4]  = 16'hD6D0 + 16'($urandom_range(200));
        w[5]  = 16'd3024 + 16'($urandom_range(200));
        w[6]  = 16'd2855 + 16'($urandom_range(200));
        w[7]  = 16'd140 + 16'($urandom_range(100));
        w[8]  = 16'hFFF9;
        w[9]  = 16'd15500 + 16'($urandom_range(200));
        w[10] = 16'hB0B4 + 16'($urandom_range(200));
        w[11] = 16'd6000 + 16'($urandom_range(200));
        write_reg(CFG_TEMP_COEFFS, {16'd0, w[2], w[1], w[0]});
        write_reg(CFG_PRESS_LOW, {w[6], w[5], w[4], w[3]});
        write_reg(CFG_PRESS_HIGH, {w[10], w[9], w[8], w[7]});
        write_reg(CFG_PRESS_NINE, {48'd0, w[11]});
    endtask

    task automatic write_random_coeffs();
        write_reg(CFG_TEMP_COEFFS, {$urandom, $urandom});
        write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
        write_reg(CFG_PRESS_HIGH, {$urandom, $urandom});
        write_reg(CFG_PRESS_NINE, {$urandom, $urandom});
    endtask

    // Raw readings mostly in the range a working sensor gives, some anywhere.
    task automatic send_random_items(int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(3) == 0)
                send_item(20'($urandom), 20'($urandom));
            else
                send_item(20'd400000 + 20'($urandom_range(200000)),
                    20'd300000 + 20'($urandom_range(200000)));
        end
    endtask

    initial
    begin
        board           = new();
        in_valid        = 1'b0;
        in_data         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_TEMP_COEFFS;
        cfg_data        = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all coefficients at reset the divisor is zero: error path.
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        drain();

        // Directed items with realistic calibration: field extremes and midscale.
        write_typical_coeffs();
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'hFFFFF, 20'd0);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'h80000, 20'h80000);
        send_item(20'h7FFFF, 20'h55555);
        send_item(20'd519888, 20'd415148);
        send_item(20'hAAAAA, 20'h2AAAA);
        drain();

        // Extreme coefficients: maxima but for t2 and t3 at minus one, then minima but for p1 at one.
        write_reg(CFG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_LOW, 64'h7FFF_7FFF_7FFF_FFFF);
        write_reg(CFG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(CFG_PRESS_NINE, 64'h7FFF);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h12345, 20'hEDCBA);
        drain();
        write_reg(CFG_TEMP_COEFFS, 64'h8000_8000_0000);
        write_reg(CFG_PRESS_LOW, 64'h8000_8000_8000_0001);
        write_reg(CFG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_reg(CFG_PRESS_NINE, 64'hFFFF_FFFF_FFFF_8000);
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h54321, 20'h0F0F0);
        drain();

        // Random part in phases of idling, with the calibration changed between.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            if (ph == 3 || ph == 7)
                write_random_coeffs();
            else
                write_typical_coeffs();
            // A long hold-off while items keep coming, so the input stalls.
            if (ph == 0)
                hold_off_cycles = 300;
            send_random_items(240);
            drain();
        end

        if (board.mismatch_count == 0 && board.pending_results.size() == 0)
            $display("[baro_temp_press_compensation_top] OK");
        else
            $display("[baro_temp_press_compensation_top] ERROR");
        $finish;
    end

endmodule
